/* rtl/assert_macros.svh */
// Assertion macros used by the frame parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define WSFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define WSFP_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/wsfp_pkg.sv */
// Types, codes and helper functions of the WebSocket frame parser.
`timescale 1ns / 1ps

package wsfp_pkg;

    localparam logic [2:0] PH_HDR0   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_KEY    = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_PING    = 2'd1;
    localparam logic [1:0] ST_CLOSE   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic [31:0] LIMIT_RESET = 32'd4095;

    typedef struct packed {
        logic        has_result;
        logic        data_valid;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [31:0] delivered_count;
    } wsfp_result_t;

    function automatic logic [1:0] status_of(input logic [3:0] op);
        logic [1:0] st;
        unique case (op)
            OP_CONT, OP_TEXT, OP_BIN, OP_PONG: st = ST_DATA;
            OP_PING:                           st = ST_PING;
            OP_CLOSE:                          st = ST_CLOSE;
            default:                           st = ST_UNKNOWN;
        endcase
        return st;
    endfunction

endpackage

/* rtl/wsfp_core.sv */
// Header and payload state machine of the frame parser, with the limit register.
`timescale 1ns / 1ps

module wsfp_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_commit,
    input  logic [7:0]            item_byte,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    output wsfp_pkg::wsfp_result_t result
);

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] idx_reg, idx_next;
    logic [31:0] limit_reg;

    logic [31:0] idx_inc;
    logic [7:0]  key_byte;
    logic        pong;
    logic        deliver;
    logic        last;

    assign idx_inc = idx_reg + 32'd1;
    assign pong    = (opcode_reg == wsfp_pkg::OP_PONG);
    assign deliver = !pong && (idx_reg < limit_reg);
    assign last    = (idx_inc == len_reg);

    always_comb
    begin
        unique case (idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        hcnt_next   = hcnt_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        result      = '0;

        unique case (phase_reg)
            wsfp_pkg::PH_HDR0:
            begin
                opcode_next = item_byte[3:0];
                mask_next   = 1'b0;
                hcnt_next   = 4'd0;
                len_next    = 32'd0;
                key_next    = 32'd0;
                idx_next    = 32'd0;
                phase_next  = wsfp_pkg::PH_HDR1;
            end
            wsfp_pkg::PH_HDR1:
            begin
                mask_next = item_byte[7];
                if (item_byte[6:0] == wsfp_pkg::LEN_EXT16)
                begin
                    phase_next = wsfp_pkg::PH_EXTLEN;
                    hcnt_next  = wsfp_pkg::EXT16_BYTES;
                end
                else if (item_byte[6:0] == wsfp_pkg::LEN_EXT64)
                begin
                    phase_next = wsfp_pkg::PH_EXTLEN;
                    hcnt_next  = wsfp_pkg::EXT64_BYTES;
                end
                else
                begin
                    len_next = {25'd0, item_byte[6:0]};
                    if (item_byte[7])
                    begin
                        phase_next = wsfp_pkg::PH_KEY;
                        hcnt_next  = wsfp_pkg::KEY_BYTES;
                    end
                    else if (item_byte[6:0] == 7'd0)
                    begin
                        phase_next          = wsfp_pkg::PH_HDR0;
                        result.has_result   = 1'b1;
                        result.frame_end    = 1'b1;
                        result.frame_status = wsfp_pkg::status_of(opcode_reg);
                    end
                    else
                    begin
                        phase_next = wsfp_pkg::PH_BODY;
                    end
                end
            end
            wsfp_pkg::PH_EXTLEN:
            begin
                len_next  = {len_reg[23:0], item_byte};
                hcnt_next = hcnt_reg - 4'd1;
                if (hcnt_next == 4'd0)
                begin
                    if (mask_reg)
                    begin
                        phase_next = wsfp_pkg::PH_KEY;
                        hcnt_next  = wsfp_pkg::KEY_BYTES;
                    end
                    else if (len_next == 32'd0)
                    begin
                        phase_next          = wsfp_pkg::PH_HDR0;
                        result.has_result   = 1'b1;
                        result.frame_end    = 1'b1;
                        result.frame_status = wsfp_pkg::status_of(opcode_reg);
                    end
                    else
                    begin
                        phase_next = wsfp_pkg::PH_BODY;
                    end
                end
            end
            wsfp_pkg::PH_KEY:
            begin
                key_next  = {key_reg[23:0], item_byte};
                hcnt_next = hcnt_reg - 4'd1;
                if (hcnt_next == 4'd0)
                begin
                    if (len_reg == 32'd0)
                    begin
                        phase_next          = wsfp_pkg::PH_HDR0;
                        result.has_result   = 1'b1;
                        result.frame_end    = 1'b1;
                        result.frame_status = wsfp_pkg::status_of(opcode_reg);
                    end
                    else
                    begin
                        phase_next = wsfp_pkg::PH_BODY;
                    end
                end
            end
            default:
            begin
                idx_next = idx_inc;
                if (last)
                begin
                    phase_next = wsfp_pkg::PH_HDR0;
                end
                result.has_result   = deliver || last;
                result.data_valid   = deliver;
                result.payload_byte = deliver ? (item_byte ^ key_byte) : 8'd0;
                result.frame_end    = last;
                result.frame_status = last ? wsfp_pkg::status_of(opcode_reg)
                                           : wsfp_pkg::ST_DATA;
                result.delivered_count = pong ? 32'd0 : (deliver ? idx_inc : limit_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsfp_pkg::PH_HDR0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            hcnt_reg   <= 4'd0;
            len_reg    <= 32'd0;
            key_reg    <= 32'd0;
            idx_reg    <= 32'd0;
        end
        else if (item_commit)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            hcnt_reg   <= hcnt_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= wsfp_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

endmodule

/* rtl/wsfp_out_reg.sv */
// Result register of the frame parser, holding one beat for the receiver.
`timescale 1ns / 1ps

module wsfp_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  wsfp_pkg::wsfp_result_t result,
    output logic                  free,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  data_valid,
    output logic [7:0]            payload_byte,
    output logic                  frame_end,
    output logic [1:0]            frame_status,
    output logic [31:0]           delivered_count
);

    logic        valid_reg;
    logic        dv_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic [1:0]  status_reg;
    logic [31:0] count_reg;

    assign free = !valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dv_reg     <= result.data_valid;
            byte_reg   <= result.payload_byte;
            end_reg    <= result.frame_end;
            status_reg <= result.frame_status;
            count_reg  <= result.delivered_count;
        end
    end

    assign res_valid       = valid_reg;
    assign data_valid      = dv_reg;
    assign payload_byte    = byte_reg;
    assign frame_end       = end_reg;
    assign frame_status    = status_reg;
    assign delivered_count = count_reg;

endmodule

/* rtl/websocket_frame_parser_top.sv */
// Top level of the WebSocket frame parser: input register, state machine, result register.
`timescale 1ns / 1ps

// The block takes one received stream byte per beat on the rx channel (rx_valid,
// rx_stall, rx_byte) and returns parsed results on the res channel (res_valid,
// res_stall and the five result fields). Header bytes, dropped bytes and pong
// payload bytes that do not end a frame give no result beat.
// The payload limit is written through cfg_valid, cfg_ready and cfg_data;
// cfg_ready is always high; the user must make writes only while the block is idle,
// as the block itself does not enforce it. A byte is held in the input register and
// is worked on by the combinational state machine; its result is loaded into the
// result register when the byte is committed, which sets res_valid.
// Throughput is one byte per cycle while neither side stalls.
// When the receiver stalls, the waiting result stays in the result register and
// bytes that give no result still pass; rx_stall is raised once the byte in the
// input register would give a result as well, and that byte is then held.
// Reset clears the parser to await the first header byte and sets the payload
// limit to 4095.

`include "assert_macros.svh"

module websocket_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        data_valid,
    output logic [7:0]  payload_byte,
    output logic        frame_end,
    output logic [1:0]  frame_status,
    output logic [31:0] delivered_count
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_free;
    logic                   commit;
    wsfp_pkg::wsfp_result_t core_result;

    assign commit    = in_valid_reg && (!core_result.has_result || out_free);
    assign rx_stall  = in_valid_reg && !commit;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    wsfp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_commit (commit),
        .item_byte   (in_byte_reg),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_wdata   (cfg_data),
        .result      (core_result)
    );

    wsfp_out_reg u_out_reg (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (commit && core_result.has_result),
        .result          (core_result),
        .free            (out_free),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .data_valid      (data_valid),
        .payload_byte    (payload_byte),
        .frame_end       (frame_end),
        .frame_status    (frame_status),
        .delivered_count (delivered_count)
    );

    `WSFP_ASSERT_IMPL(a_beat_has_meaning, res_valid, data_valid || frame_end, "empty result beat")
    `WSFP_ASSERT_IMPL(a_status_only_at_end, res_valid && !frame_end,
        frame_status == wsfp_pkg::ST_DATA, "status outside frame end")
    `WSFP_ASSERT_IMPL(a_byte_zero_when_idle, res_valid && !data_valid, payload_byte == 8'd0,
        "payload byte set without data")
    `WSFP_ASSERT(a_held_byte_kept, (in_valid_reg && !commit) |=> (in_valid_reg && $stable(in_byte_reg)),
        "held input byte lost")

endmodule
